FILE: hw/rtl/kcl_pkg.sv
package kcl_pkg;

	localparam int DEFAULT_CODE_DIGITS = 4;
	localparam int SHOWN_POSITIONS = 4;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
	localparam logic [3:0] KEY_STAR      = 4'd10;
	localparam logic [3:0] KEY_HASH      = 4'd11;

	localparam logic [1:0] REG_EXPECTED_CODE = 2'd0;
	localparam logic [1:0] REG_GOOD_HOLD     = 2'd1;
	localparam logic [1:0] REG_ERROR_HOLD    = 2'd2;

	localparam logic [1:0] MODE_CODE  = 2'd0;
	localparam logic [1:0] MODE_GOOD  = 2'd1;
	localparam logic [1:0] MODE_ERROR = 2'd2;

	localparam logic [1:0] LED_BLUE  = 2'd0;
	localparam logic [1:0] LED_GREEN = 2'd1;
	localparam logic [1:0] LED_RED   = 2'd2;

	localparam logic [15:0] EXPECTED_CODE_RESET = 16'h1234;
	localparam logic [15:0] GOOD_HOLD_RESET     = 16'd2000;
	localparam logic [15:0] ERROR_HOLD_RESET    = 16'd1000;

	localparam logic [6:0] CH_ZERO = 7'h30;
	localparam logic [6:0] CH_DASH = 7'h2D;
	localparam logic [6:0] CH_X    = 7'h58;
	localparam logic [6:0] CH_G    = 7'h47;
	localparam logic [6:0] CH_O    = 7'h4F;
	localparam logic [6:0] CH_D    = 7'h44;

	typedef struct packed {
		logic [15:0] error_hold;
		logic [15:0] good_hold;
		logic [15:0] expected_code;
	} cfg_t;

	// Updated lock state as the display needs it: the first four digits only.
	typedef struct packed {
		logic [SHOWN_POSITIONS-1:0][3:0] digits;
		logic [2:0]                      shown;
		logic [1:0]                      mode;
		logic [1:0]                      led;
		logic                            solved;
	} view_t;

	typedef struct packed {
		logic       pad;
		logic       solved;
		logic [1:0] led_colour;
		logic [6:0] char_fourth;
		logic [6:0] char_third;
		logic [6:0] char_second;
		logic [6:0] char_first;
	} result_t;

endpackage

FILE: hw/rtl/kcl_lock_fsm.sv
module kcl_lock_fsm #(
	parameter int CODE_DIGITS = kcl_pkg::DEFAULT_CODE_DIGITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  logic           opcode,
	input  logic [3:0]     key_code,
	input  kcl_pkg::cfg_t  cfg,
	output kcl_pkg::view_t view
);

	localparam int CNT_W = $clog2(CODE_DIGITS + 1);

	logic [CODE_DIGITS-1:0][3:0] digit_q, digit_n;
	logic [CNT_W-1:0]            count_q, count_n;
	logic [15:0]                 hold_q, hold_n;
	logic [1:0]                  mode_q, mode_n;
	logic [1:0]                  led_q, led_n;
	logic                        solved_q, solved_n;
	logic                        match;
	logic [31:0]                 code_ext;
	logic [15:0]                 good_len, error_len;
	logic [3:0]                  count_ext;
	logic [kcl_pkg::SHOWN_POSITIONS-1:0][3:0] shown_digits;

	assign code_ext  = {16'd0, cfg.expected_code};
	assign good_len  = (cfg.good_hold == 16'd0) ? 16'd1 : cfg.good_hold;
	assign error_len = (cfg.error_hold == 16'd0) ? 16'd1 : cfg.error_hold;

	always_comb begin
		match = (count_q == CNT_W'(CODE_DIGITS));
		for (int i = 0; i < CODE_DIGITS; i++) begin
			if (code_ext[4*(CODE_DIGITS-1-i) +: 4] != digit_q[i]) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		digit_n  = digit_q;
		count_n  = count_q;
		hold_n   = hold_q;
		mode_n   = mode_q;
		led_n    = led_q;
		solved_n = solved_q;
		if (opcode == kcl_pkg::OP_TICK) begin
			if (hold_q != 16'd0) begin
				hold_n = hold_q - 16'd1;
				if (hold_q == 16'd1) begin
					digit_n = '0;
					count_n = '0;
					mode_n  = kcl_pkg::MODE_CODE;
				end
			end
		end else if (key_code <= kcl_pkg::KEY_DIGIT_MAX) begin
			if (count_q >= CNT_W'(CODE_DIGITS)) begin
				led_n  = kcl_pkg::LED_RED;
				mode_n = kcl_pkg::MODE_ERROR;
				hold_n = error_len;
			end else begin
				for (int i = 0; i < CODE_DIGITS; i++) begin
					if (count_q == CNT_W'(i)) begin
						digit_n[i] = key_code;
					end
				end
				count_n = count_q + CNT_W'(1);
				led_n   = kcl_pkg::LED_BLUE;
				mode_n  = kcl_pkg::MODE_CODE;
				hold_n  = 16'd0;
			end
		end else if (key_code == kcl_pkg::KEY_STAR) begin
			digit_n = '0;
			count_n = '0;
			mode_n  = kcl_pkg::MODE_CODE;
			led_n   = kcl_pkg::LED_BLUE;
			hold_n  = 16'd0;
		end else if (key_code == kcl_pkg::KEY_HASH) begin
			if (match) begin
				led_n    = kcl_pkg::LED_GREEN;
				mode_n   = kcl_pkg::MODE_GOOD;
				solved_n = 1'b1;
				hold_n   = good_len;
			end else begin
				led_n  = kcl_pkg::LED_RED;
				mode_n = kcl_pkg::MODE_ERROR;
				hold_n = error_len;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q  <= '0;
			count_q  <= '0;
			hold_q   <= 16'd0;
			mode_q   <= kcl_pkg::MODE_CODE;
			led_q    <= kcl_pkg::LED_BLUE;
			solved_q <= 1'b0;
		end else if (step) begin
			digit_q  <= digit_n;
			count_q  <= count_n;
			hold_q   <= hold_n;
			mode_q   <= mode_n;
			led_q    <= led_n;
			solved_q <= solved_n;
		end
	end

	genvar p;
	generate
		for (p = 0; p < kcl_pkg::SHOWN_POSITIONS; p++) begin : g_shown
			if (p < CODE_DIGITS) begin : g_used
				assign shown_digits[p] = digit_n[p];
			end else begin : g_unused
				assign shown_digits[p] = 4'd0;
			end
		end
	endgenerate

	assign count_ext = 4'(count_n);

	always_comb begin
		view.digits = shown_digits;
		view.shown  = (count_ext >= 4'd4) ? 3'd4 : count_ext[2:0];
		view.mode   = mode_n;
		view.led    = led_n;
		view.solved = solved_n;
	end

endmodule

FILE: hw/rtl/kcl_display.sv
module kcl_display (
	input  kcl_pkg::view_t   view,
	output kcl_pkg::result_t result
);

	logic [kcl_pkg::SHOWN_POSITIONS-1:0][6:0] ch;

	always_comb begin
		for (int p = 0; p < kcl_pkg::SHOWN_POSITIONS; p++) begin
			case (view.mode)
				kcl_pkg::MODE_GOOD: begin
					ch[p] = (p == 0) ? kcl_pkg::CH_G :
						(p == kcl_pkg::SHOWN_POSITIONS - 1) ? kcl_pkg::CH_D : kcl_pkg::CH_O;
				end
				kcl_pkg::MODE_ERROR: begin
					ch[p] = kcl_pkg::CH_X;
				end
				default: begin
					if (3'(p) < view.shown) begin
						ch[p] = kcl_pkg::CH_ZERO + {3'd0, view.digits[p]};
					end else begin
						ch[p] = kcl_pkg::CH_DASH;
					end
				end
			endcase
		end
	end

	always_comb begin
		result.pad         = 1'b0;
		result.solved      = view.solved;
		result.led_colour  = view.led;
		result.char_first  = ch[0];
		result.char_second = ch[1];
		result.char_third  = ch[2];
		result.char_fourth = ch[3];
	end

endmodule

FILE: hw/rtl/kcl_out_buf.sv
module kcl_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  kcl_pkg::result_t push_data,
	output logic             push_ready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output kcl_pkg::result_t m_tdata
);

	kcl_pkg::result_t out_q, skid_q;
	logic             out_valid_q, skid_valid_q;
	logic             pop;

	assign pop        = out_valid_q && m_tready;
	assign push_ready = !skid_valid_q;
	assign m_tvalid   = out_valid_q;
	assign m_tdata    = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= push_data;
			end
		end else if (push) begin
			skid_q <= push_data;
		end
	end

endmodule

FILE: hw/rtl/keypad_code_lock.sv
// Channel    Direction  Handshake            Contents
// s_axis     in         s_tvalid / s_tready  s_tuser: opcode; s_tdata: key_code
// m_axis     out        m_tvalid / m_tready  m_tdata: four characters, LED colour, solved
// cfg        in         cfg_we               cfg_index selects the register, cfg_data the value
//
// One transaction is taken per cycle while s_tready is high; each produces one result.
// The input register feeds the lock update and display formatting, whose result lands in
// a two-entry output buffer, so input keeps flowing while one result waits downstream.
// Reset clears the entry, cancels any hold, turns the LED blue and loads the default code
// and hold lengths. A stalled output holds s_tready low only once both buffer entries and the input register fill.
module keypad_code_lock #(
	parameter int CODE_DIGITS = kcl_pkg::DEFAULT_CODE_DIGITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic        s_tuser,   // [0] opcode
	input  logic [7:0]  s_tdata,   // [3:0] key_code, [7:4] zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [6:0] char_first, [13:7] char_second,
	                               // [20:14] char_third, [27:21] char_fourth,
	                               // [29:28] led_colour, [30] solved, [31] zero
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	kcl_pkg::cfg_t    cfg_q;
	kcl_pkg::view_t   view;
	kcl_pkg::result_t result;
	kcl_pkg::result_t out_data;
	logic             valid_s1;
	logic             opcode_s1;
	logic [3:0]       key_s1;
	logic             push;
	logic             push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_code <= kcl_pkg::EXPECTED_CODE_RESET;
			cfg_q.good_hold     <= kcl_pkg::GOOD_HOLD_RESET;
			cfg_q.error_hold    <= kcl_pkg::ERROR_HOLD_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				kcl_pkg::REG_EXPECTED_CODE: cfg_q.expected_code <= cfg_data;
				kcl_pkg::REG_GOOD_HOLD:     cfg_q.good_hold     <= cfg_data;
				kcl_pkg::REG_ERROR_HOLD:    cfg_q.error_hold    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign push     = valid_s1 && push_ready;
	assign s_tready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1 <= s_tuser;
			key_s1    <= s_tdata[3:0];
		end
	end

	kcl_lock_fsm #(
		.CODE_DIGITS(CODE_DIGITS)
	) u_lock_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (push),
		.opcode   (opcode_s1),
		.key_code (key_s1),
		.cfg      (cfg_q),
		.view     (view)
	);

	kcl_display u_display (
		.view   (view),
		.result (result)
	);

	kcl_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (result),
		.push_ready (push_ready),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (out_data)
	);

	assign m_tdata = out_data;

	a_accept_loads_s1: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> valid_s1)
		else $error("Accepted transaction did not reach the input register.");

	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !push_ready |=> valid_s1 && $stable(key_s1) && $stable(opcode_s1))
		else $error("Input register changed while the output buffer was full.");

	a_green_means_solved: assert property (@(posedge clk) disable iff (!arst_n)
		push && result.led_colour == kcl_pkg::LED_GREEN |-> result.solved)
		else $error("Green LED without the solved flag.");

	a_led_code_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[29:28] != 2'b11)
		else $error("Undefined LED colour on the output.");

endmodule

FILE: tb/keypad_code_lock_checker.sv
`timescale 1ns / 100ps

module keypad_code_lock_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic        s_tuser,
	input  logic [7:0]  s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        end_of_test,
	output int          pending,
	output int          fail_count
);

	localparam int DIGITS = kcl_pkg::DEFAULT_CODE_DIGITS;

	logic [3:0]       entry [DIGITS];
	logic [2:0]       entry_len;
	logic [15:0]      hold_left;
	logic [1:0]       mode;
	logic [1:0]       led;
	logic             solved;
	logic [15:0]      code_reg;
	logic [15:0]      good_reg;
	logic [15:0]      error_reg;
	kcl_pkg::result_t display_q [$];
	kcl_pkg::result_t want;
	kcl_pkg::result_t got;
	int               results_seen;
	logic             leftover_told;

	task automatic note_failure(input string msg);
		$display("%0t ns  %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string field, input int seen, input int wanted);
		if (seen != wanted) begin
			note_failure($sformatf("result %0d: %s is %0d, expected %0d",
				results_seen, field, seen, wanted));
		end
	endtask

	function automatic logic [15:0] hold_of(input logic [15:0] ticks);
		return (ticks == 16'd0) ? 16'd1 : ticks;
	endfunction

	function automatic logic entry_is_code();
		if (entry_len != DIGITS)
			return 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (code_reg[4*(DIGITS-1-i) +: 4] != entry[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic wipe_entry();
		for (int i = 0; i < DIGITS; i++)
			entry[i] = 4'd0;
		entry_len = 3'd0;
		mode = kcl_pkg::MODE_CODE;
	endtask

	// Applies one key press or tick to the lock and returns what the display then shows.
	task automatic advance_lock(input logic op, input logic [3:0] key,
		output kcl_pkg::result_t r);
		logic [6:0] ch [kcl_pkg::SHOWN_POSITIONS];
		if (op == kcl_pkg::OP_TICK) begin
			if (hold_left != 16'd0) begin
				hold_left = hold_left - 16'd1;
				if (hold_left == 16'd0)
					wipe_entry();
			end
		end else if (key <= kcl_pkg::KEY_DIGIT_MAX) begin
			if (entry_len >= DIGITS) begin
				led = kcl_pkg::LED_RED;
				mode = kcl_pkg::MODE_ERROR;
				hold_left = hold_of(error_reg);
			end else begin
				entry[entry_len[1:0]] = key;
				entry_len = entry_len + 3'd1;
				led = kcl_pkg::LED_BLUE;
				mode = kcl_pkg::MODE_CODE;
				hold_left = 16'd0;
			end
		end else if (key == kcl_pkg::KEY_STAR) begin
			led = kcl_pkg::LED_BLUE;
			wipe_entry();
			hold_left = 16'd0;
		end else if (key == kcl_pkg::KEY_HASH) begin
			if (entry_is_code()) begin
				led = kcl_pkg::LED_GREEN;
				mode = kcl_pkg::MODE_GOOD;
				solved = 1'b1;
				hold_left = hold_of(good_reg);
			end else begin
				led = kcl_pkg::LED_RED;
				mode = kcl_pkg::MODE_ERROR;
				hold_left = hold_of(error_reg);
			end
		end

		for (int i = 0; i < kcl_pkg::SHOWN_POSITIONS; i++) begin
			case (mode)
				kcl_pkg::MODE_GOOD: begin
					ch[i] = (i == 0) ? kcl_pkg::CH_G : ((i == 3) ? kcl_pkg::CH_D : kcl_pkg::CH_O);
				end
				kcl_pkg::MODE_ERROR: begin
					ch[i] = kcl_pkg::CH_X;
				end
				default: begin
					ch[i] = (i < entry_len && i < DIGITS) ?
						kcl_pkg::CH_ZERO + {3'd0, entry[i]} : kcl_pkg::CH_DASH;
				end
			endcase
		end
		r.pad = 1'b0;
		r.solved = solved;
		r.led_colour = led;
		r.char_first = ch[0];
		r.char_second = ch[1];
		r.char_third = ch[2];
		r.char_fourth = ch[3];
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_entry();
			hold_left = 16'd0;
			led = kcl_pkg::LED_BLUE;
			solved = 1'b0;
			code_reg = kcl_pkg::EXPECTED_CODE_RESET;
			good_reg = kcl_pkg::GOOD_HOLD_RESET;
			error_reg = kcl_pkg::ERROR_HOLD_RESET;
			display_q.delete();
			results_seen = 0;
			leftover_told = 1'b0;
			fail_count = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					kcl_pkg::REG_EXPECTED_CODE: code_reg = cfg_data;
					kcl_pkg::REG_GOOD_HOLD:     good_reg = cfg_data;
					kcl_pkg::REG_ERROR_HOLD:    error_reg = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				advance_lock(s_tuser, s_tdata[3:0], want);
				display_q.push_back(want);
			end

			if (m_tvalid && m_tready) begin
				got = m_tdata;
				results_seen++;
				if (display_q.size() == 0) begin
					note_failure($sformatf("result %0d arrived with nothing expected",
						results_seen));
				end else begin
					want = display_q.pop_front();
					check_field("char_first", int'(got.char_first), int'(want.char_first));
					check_field("char_second", int'(got.char_second), int'(want.char_second));
					check_field("char_third", int'(got.char_third), int'(want.char_third));
					check_field("char_fourth", int'(got.char_fourth), int'(want.char_fourth));
					check_field("led_colour", int'(got.led_colour), int'(want.led_colour));
					check_field("solved", int'(got.solved), int'(want.solved));
					check_field("padding bit", int'(got.pad), int'(want.pad));
				end
			end

			if (end_of_test && !leftover_told) begin
				leftover_told = 1'b1;
				if (display_q.size() != 0) begin
					note_failure($sformatf("%0d expected results never arrived",
						display_q.size()));
				end
			end

			pending <= display_q.size();
		end
	end

endmodule

FILE: tb/keypad_code_lock_tb.sv
`timescale 1ns / 100ps

module keypad_code_lock_tb;

	localparam logic [1:0] REG_SPARE = 2'd3;
	localparam int PHASES = 9;
	localparam int ITEMS_PER_PHASE = 210;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic        s_tuser = 1'b0;
	logic [7:0]  s_tdata = 8'd0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [15:0] cfg_data = 16'd0;
	logic        end_of_test = 1'b0;
	int          pending;
	int          fail_count;

	logic        tx_idle = 1'b1;
	logic        rx_idle = 1'b1;
	int          items = 0;
	logic [15:0] cur_code = kcl_pkg::EXPECTED_CODE_RESET;
	logic [15:0] cur_good = kcl_pkg::GOOD_HOLD_RESET;
	logic [15:0] cur_error = kcl_pkg::ERROR_HOLD_RESET;

	always #2 clk = ~clk;

	keypad_code_lock dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tuser   (s_tuser),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	keypad_code_lock_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tuser     (s_tuser),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.end_of_test (end_of_test),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	task automatic offer(input logic op, input logic [3:0] key);
		int gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'd0, key};
		do @(posedge clk); while (!s_tready);
		if (!(op == kcl_pkg::OP_KEY && key > kcl_pkg::KEY_HASH))
			items++;
	endtask

	task automatic press(input logic [3:0] key);
		offer(kcl_pkg::OP_KEY, key);
	endtask

	task automatic tick();
		offer(kcl_pkg::OP_TICK, 4'($urandom_range(0, 15)));
	endtask

	// Holds the input back until every outstanding transaction has come out or the wait limit runs out.
	task automatic settle();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic load_config(input logic [15:0] code, input logic [15:0] good,
		input logic [15:0] err);
		cur_code = code;
		cur_good = good;
		cur_error = err;
		cfg_we <= 1'b1;
		cfg_index <= kcl_pkg::REG_EXPECTED_CODE;
		cfg_data <= code;
		@(posedge clk);
		cfg_index <= kcl_pkg::REG_GOOD_HOLD;
		cfg_data <= good;
		@(posedge clk);
		cfg_index <= kcl_pkg::REG_ERROR_HOLD;
		cfg_data <= err;
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_data <= 16'($urandom_range(0, 16'hFFFF));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly code attempts, random or aimed at the current code, then ticks around the hold length for short holds.
	task automatic play_sequence();
		int len;
		int span;
		logic aim;
		logic [3:0] d;
		tx_idle = ($urandom_range(0, 3) != 0);
		rx_idle = ($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 4))
				offer(1'($urandom_range(0, 1)), 4'($urandom_range(0, 15)));
		end else begin
			len = $urandom_range(0, 5);
			aim = 1'($urandom_range(0, 1));
			for (int i = 0; i < len; i++) begin
				d = (i < 4) ? cur_code[4*(3-i) +: 4] : 4'd0;
				if (!aim || i >= 4 || d > kcl_pkg::KEY_DIGIT_MAX)
					d = 4'($urandom_range(0, 9));
				press(d);
			end
			if ($urandom_range(0, 4) != 0)
				press(kcl_pkg::KEY_HASH);
			span = (cur_good > cur_error) ? int'(cur_good) : int'(cur_error);
			if (span > 11)
				span = 11;
			repeat ($urandom_range(0, span + 1)) tick();
			if ($urandom_range(0, 4) == 0)
				press(kcl_pkg::KEY_STAR);
		end
		if ($urandom_range(0, 40) == 0)
			settle();
	endtask

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 6) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	initial begin
		logic [15:0] bcd;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Default code and holds straight after reset.
		tick();
		press(4'd12);
		press(4'd15);
		press(kcl_pkg::KEY_HASH);
		tick();
		press(4'd1);
		press(4'd2);
		press(4'd3);
		press(kcl_pkg::KEY_HASH);
		press(4'd4);
		press(kcl_pkg::KEY_HASH);
		press(4'd9);
		press(kcl_pkg::KEY_STAR);
		press(4'd0);
		press(4'd9);
		settle();

		// One-tick good hold and a zero error hold, which behaves as one tick.
		load_config(16'h0909, 16'd1, 16'd0);
		press(kcl_pkg::KEY_STAR);
		press(4'd0);
		press(4'd9);
		press(4'd0);
		press(4'd9);
		press(kcl_pkg::KEY_HASH);
		tick();
		press(4'd5);
		press(kcl_pkg::KEY_HASH);
		tick();
		settle();

		for (int phase = 0; phase < PHASES; phase++) begin
			bcd = 16'd0;
			for (int i = 0; i < 4; i++)
				bcd = (bcd << 4) | 16'($urandom_range(0, 9));
			case (phase)
				0: load_config(16'hFFFF, 16'd3, 16'd2);
				1: load_config(16'h9999, 16'hFFFF, 16'hFFFF);
				2: load_config(16'h0000, 16'd1, 16'd1);
				7: load_config(16'($urandom_range(0, 16'hFFFF)), 16'($urandom_range(1, 9)),
					16'($urandom_range(1, 9)));
				8: load_config(kcl_pkg::EXPECTED_CODE_RESET, kcl_pkg::GOOD_HOLD_RESET,
					kcl_pkg::ERROR_HOLD_RESET);
				default: load_config(bcd, 16'($urandom_range(1, 9)),
					16'($urandom_range(0, 9)));
			endcase
			while (items < (phase + 1) * ITEMS_PER_PHASE)
				play_sequence();
			settle();
		end

		end_of_test <= 1'b1;
		repeat (3) @(posedge clk);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
